// ===== hdl/tfd_pkg.sv =====
`default_nettype none
package tfd_pkg;

  // controller states
  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_DATA,
    ST_DECODE,
    ST_TFETCH,
    ST_TCHECK,
    ST_TLAST
  } tfd_state_t;

  localparam logic [7:0] SYNC_RESET    = 8'hC8;
  localparam logic [7:0] TYPE_BATTERY  = 8'h08;
  localparam logic [7:0] TYPE_GPS      = 8'h02;
  localparam logic [7:0] TYPE_VARIO    = 8'h07;
  localparam logic [7:0] TYPE_MODE     = 8'h21;
  localparam logic [7:0] TYPE_ATTITUDE = 8'h1E;
  localparam logic [7:0] TYPE_LINK_RX  = 8'h1C;
  localparam logic [7:0] TYPE_LINK_TX  = 8'h1D;

  localparam logic [2:0] KIND_BATTERY  = 3'd0;
  localparam logic [2:0] KIND_GPS      = 3'd1;
  localparam logic [2:0] KIND_VARIO    = 3'd2;
  localparam logic [2:0] KIND_TEXT     = 3'd3;
  localparam logic [2:0] KIND_ATTITUDE = 3'd4;
  localparam logic [2:0] KIND_LINK_RX  = 3'd5;
  localparam logic [2:0] KIND_LINK_TX  = 3'd6;

  localparam logic [15:0] ALT_OFFSET = 16'd1000;

  // payload bytes that record decoding looks at
  localparam int REC_BYTES = 16;
  // text index width and longest text
  localparam int IDX_W = 6;
  localparam logic [IDX_W-1:0] TEXT_MAX = 6'd31;

  typedef struct packed {
    logic ld_len;
    logic take_byte;
    logic load_rec;
    logic text_start;
    logic load_held;
    logic emit_text;
    logic emit_last;
  } tfd_cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic len_zero;
    logic frame_end;
    logic is_rec;
    logic is_text;
    logic idx_ok;
    logic char_nul;
    logic held_valid;
    logic out_free;
  } tfd_sts_t;

endpackage
`default_nettype wire

// ===== hdl/tfd_byte_if.sv =====
`default_nettype none
interface tfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/tfd_rec_if.sv =====
`default_nettype none
interface tfd_rec_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  kind;
  logic               last;
  logic signed [31:0] word_a;
  logic signed [31:0] word_b;
  logic        [15:0] half_c;
  logic        [15:0] half_d;
  logic        [15:0] half_e;
  logic        [7:0]  byte_f;

  modport source (output valid, output kind, output last, output word_a, output word_b,
                  output half_c, output half_d, output half_e, output byte_f, input ready);
  modport sink (input valid, input kind, input last, input word_a, input word_b,
                input half_c, input half_d, input half_e, input byte_f, output ready);
endinterface
`default_nettype wire

// ===== hdl/telemetry_frame_deframer_decoder.sv =====
`default_nettype none
// channel    dir  payload                                        handshake
// rx_chan    in   rx_byte[7:0]                                   valid/ready
// rec_chan   out  kind last word_a word_b half_c half_d half_e   valid/ready
//                 byte_f
// sync_wr    in   sync_wr_data[7:0]                              sync_wr_en, no wait
//
// one received byte is taken per cycle while hunting, reading the length or collecting payload
// a record frame adds the decode state at its end, with rx ready low
// a mode text frame passes through the decode state, then the fetch and check loop over the payload
//   ram's registered read port walks the characters until a nul or the end of the text, and the last
//   held character goes out in the closing state; nothing goes out when the text holds no character
// a stalled result holds the decode or text loop; rx stays low until it moves
// synchronous reset; sync byte returns to its default, the payload ram is not cleared
module telemetry_frame_deframer_decoder #(
  parameter int PAYLOAD_STORE = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       sync_wr_en,
  input  wire logic [7:0] sync_wr_data,
  tfd_byte_if.sink        rx_chan,
  tfd_rec_if.source       rec_chan
);

  // command and status between sequencer and datapath
  tfd_pkg::tfd_cmd_t cmd;
  tfd_pkg::tfd_sts_t sts;

  // frame sequencer: sync hunt, length, payload, decode and text walk
  tfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_chan.valid),
    .rx_ready (rx_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // payload storage, field decode and the result register
  tfd_datapath #(
    .PAYLOAD_STORE (PAYLOAD_STORE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .sync_wr_en   (sync_wr_en),
    .sync_wr_data (sync_wr_data),
    .rx_byte      (rx_chan.rx_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (rec_chan.ready),
    .out_valid    (rec_chan.valid),
    .kind         (rec_chan.kind),
    .last         (rec_chan.last),
    .word_a       (rec_chan.word_a),
    .word_b       (rec_chan.word_b),
    .half_c       (rec_chan.half_c),
    .half_d       (rec_chan.half_d),
    .half_e       (rec_chan.half_e),
    .byte_f       (rec_chan.byte_f)
  );

  // a result is only loaded when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_rec || cmd.emit_text) |-> sts.out_free)
    else $error("result loaded into a full output register");

  // no byte is taken while a frame is being decoded or emitted
  a_no_rx_on_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_rec || cmd.emit_text || cmd.load_held) |-> !rx_chan.ready)
    else $error("rx ready during decode");

  // a loaded result shows up on the port next cycle
  a_emit_visible: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_rec || cmd.emit_text) |=> rec_chan.valid)
    else $error("loaded result not presented");

  // a record result is a single, final item
  a_rec_last: assert property (@(posedge clk) disable iff (rst)
    cmd.load_rec |=> rec_chan.last)
    else $error("record result without last mark");

endmodule
`default_nettype wire

// ===== hdl/tfd_ram.sv =====
`default_nettype none
module tfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/tfd_ctrl.sv =====
`default_nettype none
module tfd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            rx_valid,
  output      logic            rx_ready,
  input  wire tfd_pkg::tfd_sts_t sts,
  output      tfd_pkg::tfd_cmd_t cmd
);

  tfd_pkg::tfd_state_t state;
  tfd_pkg::tfd_state_t state_next;
  logic                rx_fire;

  assign rx_fire = rx_valid && rx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfd_pkg::ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tfd_pkg::ST_HUNT: begin
        if (rx_fire && sts.sync_hit) state_next = tfd_pkg::ST_LEN;
      end
      tfd_pkg::ST_LEN: begin
        if (rx_fire) state_next = sts.len_zero ? tfd_pkg::ST_HUNT : tfd_pkg::ST_DATA;
      end
      tfd_pkg::ST_DATA: begin
        if (rx_fire && sts.frame_end) state_next = tfd_pkg::ST_DECODE;
      end
      tfd_pkg::ST_DECODE: begin
        if (sts.is_rec) begin
          if (sts.out_free) state_next = tfd_pkg::ST_HUNT;
        end else if (sts.is_text) begin
          state_next = tfd_pkg::ST_TFETCH;
        end else begin
          state_next = tfd_pkg::ST_HUNT;
        end
      end
      tfd_pkg::ST_TFETCH: begin
        if (sts.idx_ok) state_next = tfd_pkg::ST_TCHECK;
        else state_next = sts.held_valid ? tfd_pkg::ST_TLAST : tfd_pkg::ST_HUNT;
      end
      tfd_pkg::ST_TCHECK: begin
        if (sts.char_nul) begin
          state_next = sts.held_valid ? tfd_pkg::ST_TLAST : tfd_pkg::ST_HUNT;
        end else if (!sts.held_valid || sts.out_free) begin
          state_next = tfd_pkg::ST_TFETCH;
        end
      end
      tfd_pkg::ST_TLAST: begin
        if (sts.out_free) state_next = tfd_pkg::ST_HUNT;
      end
      default: state_next = tfd_pkg::ST_HUNT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    rx_ready = 1'b0;
    case (state)
      tfd_pkg::ST_HUNT: begin
        rx_ready = 1'b1;
      end
      tfd_pkg::ST_LEN: begin
        rx_ready   = 1'b1;
        cmd.ld_len = rx_fire;
      end
      tfd_pkg::ST_DATA: begin
        rx_ready      = 1'b1;
        cmd.take_byte = rx_fire;
      end
      tfd_pkg::ST_DECODE: begin
        cmd.load_rec   = sts.is_rec && sts.out_free;
        cmd.text_start = !sts.is_rec && sts.is_text;
      end
      tfd_pkg::ST_TCHECK: begin
        if (!sts.char_nul && (!sts.held_valid || sts.out_free)) begin
          cmd.load_held = 1'b1;
          cmd.emit_text = sts.held_valid;
        end
      end
      tfd_pkg::ST_TLAST: begin
        cmd.emit_text = sts.out_free;
        cmd.emit_last = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/tfd_datapath.sv =====
`default_nettype none
module tfd_datapath #(
  parameter int PAYLOAD_STORE = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               sync_wr_en,
  input  wire logic [7:0]         sync_wr_data,
  input  wire logic [7:0]         rx_byte,
  input  wire tfd_pkg::tfd_cmd_t  cmd,
  output      tfd_pkg::tfd_sts_t  sts,
  input  wire logic               out_ready,
  output      logic               out_valid,
  output      logic [2:0]         kind,
  output      logic               last,
  output      logic signed [31:0] word_a,
  output      logic signed [31:0] word_b,
  output      logic [15:0]        half_c,
  output      logic [15:0]        half_d,
  output      logic [15:0]        half_e,
  output      logic [7:0]         byte_f
);

  localparam int AW = $clog2(PAYLOAD_STORE);
  localparam logic [8:0] STORE_LIMIT = 9'(PAYLOAD_STORE);

  logic [7:0]              sync_value;
  logic [7:0]              frame_length;
  logic [7:0]              byte_count;
  logic [7:0]              count_inc;
  logic [7:0]              rec [tfd_pkg::REC_BYTES];
  logic [7:0]              pb [tfd_pkg::REC_BYTES];
  logic [tfd_pkg::IDX_W-1:0] idx;
  logic [8:0]              idx_ext;
  logic [7:0]              held;
  logic                    held_valid;
  logic                    store_wr;
  logic [7:0]              rd_data;
  logic [AW-1:0]           rd_addr;
  logic                    out_free;

  // decoded record
  logic               is_rec;
  logic [2:0]         r_kind;
  logic [31:0]        r_a;
  logic [31:0]        r_b;
  logic [15:0]        r_c;
  logic [15:0]        r_d;
  logic [15:0]        r_e;
  logic [7:0]         r_f;
  logic [15:0]        alt_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= tfd_pkg::SYNC_RESET;
    end else if (sync_wr_en) begin
      sync_value <= sync_wr_data;
    end
  end

  assign count_inc = byte_count + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= '0;
      byte_count   <= '0;
    end else if (cmd.ld_len) begin
      frame_length <= rx_byte;
      byte_count   <= '0;
    end else if (cmd.take_byte) begin
      byte_count <= count_inc;
    end
  end

  // leading payload bytes kept in flops for record fields
  always_ff @(posedge clk) begin
    if (cmd.take_byte && byte_count < 8'(tfd_pkg::REC_BYTES)) begin
      rec[byte_count[3:0]] <= rx_byte;
    end
  end

  assign store_wr = cmd.take_byte && ({1'b0, byte_count} < STORE_LIMIT);
  assign idx_ext  = 9'(idx);
  assign rd_addr  = idx_ext[AW-1:0];

  tfd_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_STORE)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (byte_count[AW-1:0]),
    .wr_data (rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // bytes past the frame length read as zero
  always_comb begin
    for (int i = 0; i < tfd_pkg::REC_BYTES; i++) begin
      pb[i] = (8'(i) < frame_length) ? rec[i] : 8'd0;
    end
  end

  assign alt_raw = {pb[13], pb[14]};

  always_comb begin
    is_rec = 1'b1;
    r_kind = tfd_pkg::KIND_BATTERY;
    r_a    = '0;
    r_b    = '0;
    r_c    = '0;
    r_d    = '0;
    r_e    = '0;
    r_f    = '0;
    case (pb[0])
      tfd_pkg::TYPE_BATTERY: begin
        r_kind = tfd_pkg::KIND_BATTERY;
        r_a    = {8'd0, pb[5], pb[6], pb[7]};
        r_c    = {pb[1], pb[2]};
        r_d    = {pb[3], pb[4]};
        r_f    = pb[8];
      end
      tfd_pkg::TYPE_GPS: begin
        r_kind = tfd_pkg::KIND_GPS;
        r_a    = {pb[1], pb[2], pb[3], pb[4]};
        r_b    = {pb[5], pb[6], pb[7], pb[8]};
        r_c    = {pb[9], pb[10]};
        r_d    = {pb[11], pb[12]};
        r_e    = (alt_raw >= tfd_pkg::ALT_OFFSET) ? alt_raw - tfd_pkg::ALT_OFFSET : 16'd0;
        r_f    = pb[15];
      end
      tfd_pkg::TYPE_VARIO: begin
        r_kind = tfd_pkg::KIND_VARIO;
        r_a    = {{16{pb[1][7]}}, pb[1], pb[2]};
      end
      tfd_pkg::TYPE_ATTITUDE: begin
        r_kind = tfd_pkg::KIND_ATTITUDE;
        r_c    = {pb[1], pb[2]};
        r_d    = {pb[3], pb[4]};
        r_e    = {pb[5], pb[6]};
      end
      tfd_pkg::TYPE_LINK_RX: begin
        r_kind = tfd_pkg::KIND_LINK_RX;
        r_c    = {8'd0, pb[2]};
        r_f    = pb[1];
      end
      tfd_pkg::TYPE_LINK_TX: begin
        r_kind = tfd_pkg::KIND_LINK_TX;
        r_c    = {8'd0, pb[2]};
        r_d    = {8'd0, pb[3]};
        r_f    = pb[1];
      end
      default: is_rec = 1'b0;
    endcase
  end

  // text walk
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      held_valid <= 1'b0;
    end else if (cmd.text_start) begin
      idx        <= tfd_pkg::IDX_W'(1);
      held_valid <= 1'b0;
    end else if (cmd.load_held) begin
      idx        <= idx + tfd_pkg::IDX_W'(1);
      held_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_held) begin
      held <= rd_data;
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_rec || cmd.emit_text) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rec) begin
      kind   <= r_kind;
      last   <= 1'b1;
      word_a <= r_a;
      word_b <= r_b;
      half_c <= r_c;
      half_d <= r_d;
      half_e <= r_e;
      byte_f <= r_f;
    end else if (cmd.emit_text) begin
      kind   <= tfd_pkg::KIND_TEXT;
      last   <= cmd.emit_last;
      word_a <= '0;
      word_b <= '0;
      half_c <= '0;
      half_d <= '0;
      half_e <= '0;
      byte_f <= held;
    end
  end

  always_comb begin
    sts            = '0;
    sts.sync_hit   = (rx_byte == sync_value);
    sts.len_zero   = (rx_byte == 8'd0);
    sts.frame_end  = (count_inc >= frame_length);
    sts.is_rec     = is_rec;
    sts.is_text    = (pb[0] == tfd_pkg::TYPE_MODE);
    sts.idx_ok     = (idx <= tfd_pkg::TEXT_MAX) && (8'(idx) < frame_length)
                     && (idx_ext < STORE_LIMIT);
    sts.char_nul   = (rd_data == 8'd0);
    sts.held_valid = held_valid;
    sts.out_free   = out_free;
  end

endmodule
`default_nettype wire
